FILE: rtl/lca_pkg.sv
`timescale 1ns / 1ps

package lca_pkg;

   // Default table geometry, handed down from the top level.
   localparam int SLOTS_DEF     = 256;
   localparam int KEY_BITS_DEF  = 64;

   // Fixed field widths on the streaming ports.
   localparam int REQ_DATA_BITS = 64;
   localparam int SLOT_BITS     = 8;
   localparam int RSP_DATA_BITS = 16;

   typedef enum logic [7:0] {
      ST_CLEAR    = 8'b0000_0001,
      ST_IDLE     = 8'b0000_0010,
      ST_SCAN     = 8'b0000_0100,
      ST_SCAN_END = 8'b0000_1000,
      ST_SELECT   = 8'b0001_0000,
      ST_UPDATE   = 8'b0010_0000,
      ST_UPD_END  = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_wr;   // write reset values at the counter address
      logic cnt_clr;    // return the slot counter to zero
      logic cnt_step;   // advance the slot counter
      logic load_key;   // capture the request key and clear the match flag
      logic scan_rd;    // read key and rank at the counter address for the search
      logic do_select;  // settle the chosen slot, store the key on a miss
      logic upd_rd;     // read a rank at the counter address for the rank update
      logic rsp_load;   // move the result into the output register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cnt_last;   // counter stands at the last slot
      logic rsp_free;   // output register can take a result this cycle
   } ctrl_sts_type;

endpackage

FILE: rtl/lru_channel_id_allocator.sv
`timescale 1ns / 1ps

// Channel number allocator over a fully associative table with LRU eviction.
// Requests arrive on the req_ stream: req_tdata carries the channel key (its low
// KEY_BITS bits are used; key zero is the empty identifier). Each request yields
// exactly one response on the rsp_ stream with the slot given to the key and a
// hit flag, set when the key was already held.
// A request runs as one search pass over every slot (first match, least recent
// rank), a select step, then a pass rewriting every rank. Both passes are set
// by the single read port of the key and rank memories, one slot per cycle.
// After reset a clearing pass writes the empty key and the rank equal to the
// index into every slot; req_tready stays low until it is done.
// The response waits in an output register. A stalled receiver does not stop
// the next request from being accepted and worked on; only the hand-over of the
// following response waits until the register has been emptied.

module lru_channel_id_allocator #(
   parameter int SLOTS    = lca_pkg::SLOTS_DEF,
   parameter int KEY_BITS = lca_pkg::KEY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata fields from bit 0: key[63:0]
   input  logic [lca_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata fields from bit 0: slot[7:0], hit[8], zero padding[15:9]
   output logic [lca_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   import lca_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // The sequencer walks the clearing, search and rank-update passes.
   lca_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The datapath holds both memories, the search results and the output register.
   lca_datapath #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: rtl/lca_ram.sv
`timescale 1ns / 1ps

module lca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lca_datapath.sv
`timescale 1ns / 1ps

module lca_datapath #(
   parameter int SLOTS    = lca_pkg::SLOTS_DEF,
   parameter int KEY_BITS = lca_pkg::KEY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lca_pkg::ctrl_cmd_type             cmd,
   output lca_pkg::ctrl_sts_type             sts,
   input  logic [lca_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lca_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   import lca_pkg::*;

   localparam int IDX_BITS = $clog2(SLOTS);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SLOTS - 1);

   logic [IDX_BITS-1:0] cnt_ff, cnt_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                rd_scan_ff, rd_upd_ff;
   logic [IDX_BITS-1:0] rd_addr_ff;
   logic                found_ff, found_in;
   logic [IDX_BITS-1:0] match_idx_ff, match_idx_in;
   logic [IDX_BITS-1:0] match_rank_ff, match_rank_in;
   logic [IDX_BITS-1:0] best_idx_ff, best_idx_in;
   logic [IDX_BITS-1:0] best_rank_ff, best_rank_in;
   logic [IDX_BITS-1:0] sel_ff, sel_in;
   logic [IDX_BITS-1:0] old_ff, old_in;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_BITS-1:0] rsp_slot_ff, rsp_slot_in;
   logic                rsp_hit_ff, rsp_hit_in;

   logic                key_wr_en;
   logic [IDX_BITS-1:0] key_wr_addr;
   logic [KEY_BITS-1:0] key_wr_data;
   logic [KEY_BITS-1:0] key_rd;
   logic                rank_wr_en;
   logic [IDX_BITS-1:0] rank_wr_addr;
   logic [IDX_BITS-1:0] rank_wr_data;
   logic [IDX_BITS-1:0] rank_rd;
   logic [IDX_BITS-1:0] rank_next;
   logic [SLOT_BITS+IDX_BITS-1:0] slot_wide;

   lca_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (cmd.scan_rd),
      .rd_addr (cnt_ff),
      .rd_data (key_rd)
   );

   lca_ram #(.WIDTH(IDX_BITS), .DEPTH(SLOTS)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_wr_en),
      .wr_addr (rank_wr_addr),
      .wr_data (rank_wr_data),
      .rd_en   (cmd.scan_rd | cmd.upd_rd),
      .rd_addr (cnt_ff),
      .rd_data (rank_rd)
   );

   // Key store: reset pass writes the empty key, a miss stores the new key.
   assign key_wr_en   = cmd.clear_wr | (cmd.do_select & ~found_ff);
   assign key_wr_addr = cmd.clear_wr ? cnt_ff : sel_in;
   assign key_wr_data = cmd.clear_wr ? '0 : key_ff;

   // Rank write-back: the chosen slot becomes most recent, younger slots age by one.
   always_comb begin
      if (rd_addr_ff == sel_ff) begin
         rank_next = LAST_IDX;
      end else if (rank_rd > old_ff) begin
         rank_next = rank_rd - IDX_BITS'(1);
      end else begin
         rank_next = rank_rd;
      end
   end

   assign rank_wr_en   = cmd.clear_wr | rd_upd_ff;
   assign rank_wr_addr = cmd.clear_wr ? cnt_ff : rd_addr_ff;
   assign rank_wr_data = cmd.clear_wr ? cnt_ff : rank_next;

   always_comb begin
      cnt_in        = cnt_ff;
      key_in        = key_ff;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      match_rank_in = match_rank_ff;
      best_idx_in   = best_idx_ff;
      best_rank_in  = best_rank_ff;
      sel_in        = sel_ff;
      old_in        = old_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_hit_in    = rsp_hit_ff;

      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_step) begin
         cnt_in = cnt_ff + IDX_BITS'(1);
      end

      if (cmd.load_key) begin
         key_in   = req_tdata[KEY_BITS-1:0];
         found_in = 1'b0;
      end

      if (rd_scan_ff) begin
         if (!found_ff && key_rd == key_ff) begin
            found_in      = 1'b1;
            match_idx_in  = rd_addr_ff;
            match_rank_in = rank_rd;
         end
         if (rd_addr_ff == '0 || rank_rd < best_rank_ff) begin
            best_idx_in  = rd_addr_ff;
            best_rank_in = rank_rd;
         end
      end

      if (cmd.do_select) begin
         sel_in = found_ff ? match_idx_ff : best_idx_ff;
         old_in = found_ff ? match_rank_ff : best_rank_ff;
         hit_in = found_ff;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = slot_wide[SLOT_BITS-1:0];
         rsp_hit_in   = hit_ff;
      end
   end

   assign slot_wide = {SLOT_BITS'(0), sel_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rd_scan_ff   <= 1'b0;
         rd_upd_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rd_scan_ff   <= cmd.scan_rd;
         rd_upd_ff    <= cmd.upd_rd;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff    <= cnt_ff;
      key_ff        <= key_in;
      found_ff      <= found_in;
      match_idx_ff  <= match_idx_in;
      match_rank_ff <= match_rank_in;
      best_idx_ff   <= best_idx_in;
      best_rank_ff  <= best_rank_in;
      sel_ff        <= sel_in;
      old_ff        <= old_in;
      hit_ff        <= hit_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_hit_ff    <= rsp_hit_in;
   end

   assign sts.cnt_last = (cnt_ff == LAST_IDX);
   assign sts.rsp_free = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_hit_ff, rsp_slot_ff});

endmodule

FILE: rtl/lca_controller.sv
`timescale 1ns / 1ps

module lca_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output lca_pkg::ctrl_cmd_type cmd,
   input  lca_pkg::ctrl_sts_type sts
);

   import lca_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.cnt_step = 1'b1;
            if (sts.cnt_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.cnt_clr = 1'b1;
            if (req_tvalid) begin
               cmd.load_key = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd  = 1'b1;
            cmd.cnt_step = 1'b1;
            if (sts.cnt_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_SELECT;
         end
         ST_SELECT: begin
            cmd.do_select = 1'b1;
            cmd.cnt_clr   = 1'b1;
            state_in      = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.upd_rd   = 1'b1;
            cmd.cnt_step = 1'b1;
            if (sts.cnt_last) begin
               state_in = ST_UPD_END;
            end
         end
         ST_UPD_END: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            cmd.cnt_clr = 1'b1;
            state_in    = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   a_state_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state lost its one-hot form");

   a_accept_starts_scan : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a search");

   a_rsp_load_free : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("result loaded over one not yet taken");

   a_no_accept_while_busy : assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_rd || cmd.upd_rd || cmd.clear_wr) |-> !req_tready)
      else $error("request channel ready while a table pass runs");

endmodule
